// ===== rtl/core/tct_pkg.sv =====
`timescale 1ns / 1ps
package tct_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0] ATTR_RESET = 8'h07;
  localparam logic [7:0] BLANK_CHAR = 8'h20;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_PRINT_LO  = 8'h20;
  localparam logic [7:0] CH_PRINT_HI  = 8'h7F;

  // tab stops every eight columns
  localparam logic [7:0] TAB_STEP = 8'd8;
  localparam logic [7:0] TAB_MASK = ~8'd7;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_SETCUR = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    CLS_IGNORE    = 4'd0,
    CLS_PRINT     = 4'd1,
    CLS_NEWLINE   = 4'd2,
    CLS_BACKSPACE = 4'd3,
    CLS_TAB       = 4'd4,
    CLS_SETCUR    = 4'd5,
    CLS_CLEAR     = 4'd6,
    CLS_READ      = 4'd7,
    CLS_READ_ZERO = 4'd8
  } cls_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
    logic [7:0] column;
    logic [7:0] row;
  } in_data_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_offset;
    logic        scrolled;
  } out_data_t;

  // classified command as it sits in the queue
  typedef struct packed {
    cls_t       cls;
    logic [7:0] ch;
    logic [6:0] col;
    logic [4:0] row;
  } cmd_t;

endpackage

// ===== rtl/core/text_console_teletype.sv =====
`timescale 1ns / 1ps
// text console: a ROWS x COLUMNS cell store plus a teletype cursor
// input channel (in_valid / in_stall / in_data) carries one command per
// transaction: put character, set cursor, clear screen or read cell
// output channel (out_valid / out_stall / out_data) returns exactly one
// result per command, in order: read data, cursor after the command, the
// linear cursor offset and a scrolled flag
// cfg_wr_en / cfg_wr_data write the attribute byte used for new cells;
// write it only while no command is in flight
// results are registered; tab, newline without scroll, set cursor, off-screen
// reads and ignored bytes finish in dispatch, printable, backspace and on-screen
// reads pass through a memory state, and clear and scroll sweep the cell memory
// sustained rate: one command per cycle for cursor-only work while the output
// is not stalled; a cell write or an on-screen read also passes through the
// ST_PUT or ST_RD_WAIT memory state before the next command is taken
// commands sit in a two-deep queue, so input keeps flowing while a stalled
// result waits in the output register; once both are full in_stall rises
// reset clears the cursor to the top left, the attribute to 0x07 and the
// queue; cell contents are unknown until the first clear
module text_console_teletype import tct_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_data_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_data_t out_data,
  input  logic      cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  // attribute register, written from the config port
  logic [7:0] attr_r;
  logic [7:0] attr_nxt;

  // front to queue
  logic q_push;
  cmd_t push_cmd;
  logic q_full;

  // queue to back
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  assign attr_nxt = cfg_wr_en ? cfg_wr_data : attr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else begin
      attr_r <= attr_nxt;
    end
  end

  // decode and range check of each incoming transaction
  tct_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (push_cmd)
  );

  // decouples intake from the cell sequencer
  tct_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .q_valid (q_valid),
    .q_cmd   (q_cmd)
  );

  // cursor, cell memory, scroll and clear sweeps, result register
  tct_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .attr     (attr_r),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// ===== rtl/core/tct_front.sv =====
`timescale 1ns / 1ps
module tct_front import tct_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic     in_valid,
  output logic     in_stall,
  input  in_data_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  localparam logic [7:0] COLS_B = 8'(COLUMNS);
  localparam logic [7:0] ROWS_B = 8'(ROWS);

  logic in_range;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign in_range = (in_data.column < COLS_B) && (in_data.row < ROWS_B);

  always_comb begin
    q_cmd.ch  = in_data.char_code;
    q_cmd.col = in_data.column[6:0];
    q_cmd.row = in_data.row[4:0];
    q_cmd.cls = CLS_IGNORE;
    case (func_t'(in_data.func))
      FUNC_PUT: begin
        if (in_data.char_code == CH_LF || in_data.char_code == CH_CR) begin
          q_cmd.cls = CLS_NEWLINE;
        end else if (in_data.char_code == CH_BACKSPACE) begin
          q_cmd.cls = CLS_BACKSPACE;
        end else if (in_data.char_code == CH_TAB) begin
          q_cmd.cls = CLS_TAB;
        end else if (in_data.char_code >= CH_PRINT_LO && in_data.char_code <= CH_PRINT_HI) begin
          q_cmd.cls = CLS_PRINT;
        end
      end
      FUNC_SETCUR: q_cmd.cls = in_range ? CLS_SETCUR : CLS_IGNORE;
      FUNC_CLEAR:  q_cmd.cls = CLS_CLEAR;
      FUNC_READ:   q_cmd.cls = in_range ? CLS_READ : CLS_READ_ZERO;
      default:     q_cmd.cls = CLS_IGNORE;
    endcase
  end

endmodule

// ===== rtl/core/tct_queue.sv =====
`timescale 1ns / 1ps
module tct_queue import tct_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt_r == (QPTR_W + 1)'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
    end
  end

  // occupancy never runs past the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_W + 1)'(QDEPTH))
    else $error("queue occupancy out of range");

endmodule

// ===== rtl/core/tct_back.sv =====
`timescale 1ns / 1ps
module tct_back import tct_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] attr,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output out_data_t  out_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  localparam logic [AW-1:0] MOVE_LAST = AW'((ROWS - 1) * COLUMNS - 1);
  localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
  localparam logic [7:0]    COLS_B    = 8'(COLUMNS);
  localparam logic [7:0]    COLS_M1   = 8'(COLUMNS - 1);
  localparam logic [4:0]    ROWS_M1   = 5'(ROWS - 1);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_PUT     = 6'b000010,
    ST_RD_WAIT = 6'b000100,
    ST_SCR_RD  = 6'b001000,
    ST_SCR_WR  = 6'b010000,
    ST_BLANK   = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [7:0]      col_r, col_nxt;
  logic [4:0]      row_r, row_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic            scr_r, scr_nxt;
  logic [7:0]      put_ch_r, put_ch_nxt;
  logic            put_inc_r, put_inc_nxt;
  logic            pend_r, pend_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_data_t       out_r, out_nxt;

  logic [15:0]     cell_mem_r [CELLS];
  logic [15:0]     rd_data_r;
  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  logic [15:0]     wdata;

  logic            slot_ok;
  logic            fin;
  logic [15:0]     fin_cell;
  logic            last_row;
  logic [7:0]      tab_sum;
  logic [7:0]      tab_col;
  logic [6:0]      mul_col;
  logic [4:0]      mul_row;
  logic [AW-1:0]   lin_addr;

  assign slot_ok  = !out_valid_r || !out_stall;
  assign last_row = (row_r == ROWS_M1);
  assign tab_sum  = (col_r + TAB_STEP) & TAB_MASK;
  assign tab_col  = (tab_sum > COLS_B) ? COLS_B : tab_sum;

  // one row * columns + column unit shared by the read and put cell addresses
  assign mul_col  = state_r == ST_IDLE ? q_cmd.col : col_r[6:0];
  assign mul_row  = state_r == ST_IDLE ? q_cmd.row : row_r;
  assign lin_addr = AW'(int'(mul_row) * COLUMNS + int'(mul_col));

  always_comb begin
    state_nxt   = state_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    idx_nxt     = idx_r;
    scr_nxt     = scr_r;
    put_ch_nxt  = put_ch_r;
    put_inc_nxt = put_inc_r;
    pend_nxt    = pend_r;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = idx_r;
    raddr       = lin_addr;
    wdata       = {attr, BLANK_CHAR};
    q_pop       = 1'b0;
    fin         = 1'b0;
    fin_cell    = '0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && slot_ok) begin
          q_pop   = 1'b1;
          scr_nxt = 1'b0;
          case (q_cmd.cls)
            CLS_SETCUR: begin
              col_nxt = {1'b0, q_cmd.col};
              row_nxt = q_cmd.row;
              fin     = 1'b1;
            end
            CLS_TAB: begin
              col_nxt = tab_col;
              fin     = 1'b1;
            end
            CLS_NEWLINE: begin
              col_nxt = '0;
              if (last_row) begin
                scr_nxt   = 1'b1;
                idx_nxt   = '0;
                pend_nxt  = 1'b0;
                state_nxt = ST_SCR_RD;
              end else begin
                row_nxt = row_r + 5'd1;
                fin     = 1'b1;
              end
            end
            CLS_BACKSPACE: begin
              if (col_r != '0) begin
                col_nxt = col_r - 8'd1;
              end else if (row_r != '0) begin
                row_nxt = row_r - 5'd1;
                col_nxt = COLS_M1;
              end
              put_ch_nxt  = BLANK_CHAR;
              put_inc_nxt = 1'b0;
              state_nxt   = ST_PUT;
            end
            CLS_PRINT: begin
              put_ch_nxt  = q_cmd.ch;
              put_inc_nxt = 1'b1;
              state_nxt   = ST_PUT;
              if (col_r >= COLS_B) begin
                col_nxt = '0;
                if (last_row) begin
                  scr_nxt   = 1'b1;
                  idx_nxt   = '0;
                  pend_nxt  = 1'b1;
                  state_nxt = ST_SCR_RD;
                end else begin
                  row_nxt = row_r + 5'd1;
                end
              end
            end
            CLS_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              idx_nxt   = '0;
              pend_nxt  = 1'b0;
              state_nxt = ST_BLANK;
            end
            CLS_READ: begin
              re        = 1'b1;
              state_nxt = ST_RD_WAIT;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      ST_PUT: begin
        we    = 1'b1;
        waddr = lin_addr;
        wdata = {attr, put_ch_r};
        if (put_inc_r) begin
          col_nxt = col_r + 8'd1;
        end
        fin       = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_RD_WAIT: begin
        fin       = 1'b1;
        fin_cell  = rd_data_r;
        state_nxt = ST_IDLE;
      end
      ST_SCR_RD: begin
        re        = 1'b1;
        raddr     = idx_r + ROW_STEP;
        state_nxt = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        we        = 1'b1;
        wdata     = rd_data_r;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = (idx_r == MOVE_LAST) ? ST_BLANK : ST_SCR_RD;
      end
      ST_BLANK: begin
        we      = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == CELL_LAST) begin
          if (pend_r) begin
            state_nxt = ST_PUT;
          end else begin
            fin       = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (fin) begin
      out_valid_nxt         = 1'b1;
      out_nxt.cell_value    = fin_cell;
      out_nxt.cursor_column = col_nxt[6:0];
      out_nxt.cursor_row    = row_nxt;
      out_nxt.cursor_offset = 11'(int'(row_nxt) * COLUMNS + int'(col_nxt));
      out_nxt.scrolled      = scr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      cell_mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= cell_mem_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    scr_r     <= scr_nxt;
    put_ch_r  <= put_ch_nxt;
    put_inc_r <= put_inc_nxt;
    pend_r    <= pend_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= ROWS_M1 && col_r <= COLS_B)
    else $error("cursor outside screen");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !fin)
    else $error("result finished while output held");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == ST_IDLE && slot_ok)
    else $error("command taken while busy");

  a_scroll_flag: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCR_RD || state_r == ST_SCR_WR |-> scr_r)
    else $error("row move without scroll flag");

endmodule

// ===== sim/text_console_teletype_test.sv =====
`timescale 1ns / 1ps
module text_console_teletype_test;
  import tct_pkg::*;

  localparam int COLS  = COLUMNS_DEF;
  localparam int LINES = ROWS_DEF;
  localparam int CELLS = COLS * LINES;
  // worst-case busy time of the block for a clear and for a scroll
  localparam int CLEAR_CYCLES  = CELLS + 2;
  localparam int SCROLL_CYCLES = 2 * (LINES - 1) * COLS + COLS;
  localparam int RANDOM_CMDS   = 1300;
  localparam int CALM_FROM     = 1150;

  // one entry of the stimulus feed: a command or an attribute write
  typedef struct {
    logic       is_cfg;
    logic       calm;
    logic [7:0] attr;
    in_data_t   cmd;
  } feed_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_data_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_data_t  out_data;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;

  // stimulus feed and the console results still owed by the block
  feed_t     pending[$];
  out_data_t results_due[$];

  // console image as the block should hold it
  logic [15:0] screen_mem [CELLS];
  logic [6:0]  cur_x = '0;
  logic [4:0]  cur_y = '0;
  logic [7:0]  attr_now = ATTR_RESET;

  // handshake and pacing state
  logic      in_fire = 1'b0;
  logic      in_quiet = 1'b0;
  logic      calm_mode = 1'b0;
  int        in_gap = 0;
  int        out_hold = 0;
  out_data_t predicted;
  out_data_t want;

  // bookkeeping
  int cycle_count = 0;
  int cycle_limit = 20000;
  int mismatches = 0;
  int n_cmds = 0;
  int n_reads = 0;
  int n_clears = 0;
  int n_scrolls = 0;
  int n_attr = 0;

  text_console_teletype dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------
  // console model
  // ---------------------------------------------------------------------

  // move to column 0 of the next row, scrolling at the bottom; 1 if scrolled
  function automatic logic advance_line();
    cur_x = '0;
    if (int'(cur_y) + 1 >= LINES) begin
      for (int i = 0; i < (LINES - 1) * COLS; i++) begin
        screen_mem[i] = screen_mem[i + COLS];
      end
      // bottom row is refilled with blanks in the current attribute
      for (int i = (LINES - 1) * COLS; i < CELLS; i++) begin
        screen_mem[i] = {attr_now, BLANK_CHAR};
      end
      cur_y = 5'(LINES - 1);
      return 1'b1;
    end
    cur_y = cur_y + 5'd1;
    return 1'b0;
  endfunction

  // apply one command to the console image and build the result it yields
  function automatic out_data_t console_step(in_data_t cmd);
    out_data_t  r;
    logic       rolled;
    int         tab_col;
    logic [7:0] ch;
    r = '0;
    rolled = 1'b0;
    ch = cmd.char_code;
    case (func_t'(cmd.func))
      FUNC_PUT: begin
        if (ch == CH_LF || ch == CH_CR) begin
          rolled = advance_line();
        end else if (ch == CH_BACKSPACE) begin
          // step back, climbing to the row above at column 0; corner stays put
          if (cur_x > 0) begin
            cur_x = cur_x - 7'd1;
          end else if (cur_y > 0) begin
            cur_y = cur_y - 5'd1;
            cur_x = 7'(COLS - 1);
          end
          screen_mem[int'(cur_y) * COLS + int'(cur_x)] = {attr_now, BLANK_CHAR};
        end else if (ch == CH_TAB) begin
          // next tab stop, never past the pending-wrap column
          tab_col = (int'(cur_x) + int'(TAB_STEP)) / int'(TAB_STEP) * int'(TAB_STEP);
          cur_x = 7'((tab_col > COLS) ? COLS : tab_col);
        end else if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
          // a pending wrap is taken before the character lands
          if (int'(cur_x) >= COLS) begin
            rolled = advance_line();
          end
          screen_mem[int'(cur_y) * COLS + int'(cur_x)] = {attr_now, ch};
          cur_x = cur_x + 7'd1;
        end
      end
      FUNC_SETCUR: begin
        if (int'(cmd.column) < COLS && int'(cmd.row) < LINES) begin
          cur_x = 7'(cmd.column);
          cur_y = 5'(cmd.row);
        end
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          screen_mem[i] = {attr_now, BLANK_CHAR};
        end
        cur_x = '0;
        cur_y = '0;
      end
      FUNC_READ: begin
        if (int'(cmd.column) < COLS && int'(cmd.row) < LINES) begin
          r.cell_value = screen_mem[int'(cmd.row) * COLS + int'(cmd.column)];
        end
      end
      default: ;
    endcase
    r.cursor_column = cur_x;
    r.cursor_row    = cur_y;
    r.cursor_offset = 11'(int'(cur_y) * COLS + int'(cur_x));
    r.scrolled      = rolled;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] expected, logic [15:0] actual);
    if (actual !== expected) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h",
               $time, name, expected, actual);
    end
  endtask

  // ---------------------------------------------------------------------
  // stimulus feed
  // ---------------------------------------------------------------------

  task automatic queue_cmd(func_t f, logic [7:0] ch, logic [7:0] col, logic [7:0] row);
    feed_t e;
    e.is_cfg = 1'b0;
    e.calm = calm_mode;
    e.attr = '0;
    e.cmd.func = f;
    e.cmd.char_code = ch;
    e.cmd.column = col;
    e.cmd.row = row;
    pending.push_back(e);
    // input gap, output stall and the block's own cycles, with margin
    cycle_limit += 200;
  endtask

  task automatic queue_attr(logic [7:0] value);
    feed_t e;
    e.is_cfg = 1'b1;
    e.calm = calm_mode;
    e.attr = value;
    e.cmd = '0;
    pending.push_back(e);
    cycle_limit += 200;
  endtask

  // ---------------------------------------------------------------------
  // input driver: one transaction per accepted command, attribute writes
  // only once the block has returned everything it owes
  // ---------------------------------------------------------------------
  always @(negedge clk) begin : drive_inputs
    logic     nv;
    logic     os;
    logic     ce;
    in_data_t nd;
    feed_t    head;
    if (rst_n) begin
      nv = in_valid;
      nd = in_data;
      ce = 1'b0;
      // the command on the bus was taken at the last rising edge
      if (in_valid && in_fire) begin
        nv = 1'b0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending.size() > 0) begin
          head = pending[0];
          if (head.is_cfg) begin
            // idle block: nothing on the bus and no result outstanding
            if (results_due.size() == 0) begin
              ce = 1'b1;
              cfg_wr_data <= head.attr;
              void'(pending.pop_front());
            end
          end else if (!head.calm && $urandom_range(0, 9) == 0) begin
            // start an idle burst; in_gap counts the idle cycles still to come
            in_gap = $urandom_range(0, 15);
          end else begin
            nd = head.cmd;
            nv = 1'b1;
            in_quiet = head.calm;
            void'(pending.pop_front());
          end
        end
      end
      // result side holds off in bursts; out_hold counts the stalled cycles still to come
      if (out_hold == 0 && !in_quiet && $urandom_range(0, 9) == 0) begin
        out_hold = $urandom_range(1, 16);
      end
      os = (out_hold != 0);
      if (os) begin
        out_hold--;
      end
      in_valid  <= nv;
      in_data   <= nd;
      out_stall <= os;
      cfg_wr_en <= ce;
    end
  end

  // ---------------------------------------------------------------------
  // monitor: predict at command acceptance, check at result acceptance
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        attr_now = cfg_wr_data;
        n_attr++;
      end
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        predicted = console_step(in_data);
        results_due.push_back(predicted);
        n_cmds++;
        // long operations stretch the time limit as they are taken
        if (func_t'(in_data.func) == FUNC_CLEAR) begin
          n_clears++;
          cycle_limit += 4 * CLEAR_CYCLES;
        end
        if (func_t'(in_data.func) == FUNC_READ) begin
          n_reads++;
        end
        if (predicted.scrolled) begin
          n_scrolls++;
          cycle_limit += 4 * SCROLL_CYCLES;
        end
      end
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with none expected, expected nothing, actual %h",
                   $time, out_data);
        end else begin
          want = results_due.pop_front();
          check_field("cell_value", want.cell_value, out_data.cell_value);
          check_field("cursor_column", 16'(want.cursor_column), 16'(out_data.cursor_column));
          check_field("cursor_row", 16'(want.cursor_row), 16'(out_data.cursor_row));
          check_field("cursor_offset", 16'(want.cursor_offset), 16'(out_data.cursor_offset));
          check_field("scrolled", 16'(want.scrolled), 16'(out_data.scrolled));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------
  initial begin
    while (cycle_count < cycle_limit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t ns: no progress within %0d cycles, %0d results outstanding",
             $time, cycle_limit, results_due.size());
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    int         k;
    int         roll;
    int         phase;
    int         next_phase;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;

    // directed part; the screen is cleared before any read
    queue_attr(8'hFF);
    queue_cmd(FUNC_CLEAR, 8'h00, 8'h00, 8'h00);
    queue_cmd(FUNC_PUT, 8'h41, 8'h00, 8'h00);
    queue_cmd(FUNC_PUT, CH_PRINT_HI, 8'hFF, 8'hFF);
    queue_cmd(FUNC_PUT, CH_PRINT_LO, 8'h00, 8'h00);
    // high bytes and stray control bytes change nothing; then a tab, a backspace and a read
    queue_cmd(FUNC_PUT, 8'h80, 8'h00, 8'h00);
    queue_cmd(FUNC_PUT, 8'hFF, 8'h00, 8'h00);
    queue_cmd(FUNC_PUT, 8'h00, 8'h00, 8'h00);
    queue_cmd(FUNC_PUT, CH_TAB, 8'h00, 8'h00);
    queue_cmd(FUNC_PUT, CH_BACKSPACE, 8'h00, 8'h00);
    queue_cmd(FUNC_READ, 8'h00, 8'h00, 8'h00);
    // pending wrap on the bottom row: tab saturates, backspace steps back, then one
    // character refills the last column and the next one wraps and scrolls
    queue_cmd(FUNC_SETCUR, 8'h00, 8'(COLS - 1), 8'(LINES - 1));
    queue_cmd(FUNC_PUT, 8'h61, 8'h00, 8'h00);
    queue_cmd(FUNC_PUT, CH_TAB, 8'h00, 8'h00);
    queue_cmd(FUNC_PUT, CH_BACKSPACE, 8'h00, 8'h00);
    queue_cmd(FUNC_PUT, 8'h62, 8'h00, 8'h00);
    queue_cmd(FUNC_PUT, 8'h63, 8'h00, 8'h00);
    queue_cmd(FUNC_PUT, CH_LF, 8'h00, 8'h00);
    // backspace climbs a row, and does nothing but blank at the corner
    queue_cmd(FUNC_SETCUR, 8'h00, 8'h00, 8'h01);
    queue_cmd(FUNC_PUT, CH_BACKSPACE, 8'h00, 8'h00);
    queue_cmd(FUNC_SETCUR, 8'h00, 8'h00, 8'h00);
    queue_cmd(FUNC_PUT, CH_BACKSPACE, 8'h00, 8'h00);
    // off-screen positions: cursor ignored, an off-screen read gives zero
    queue_cmd(FUNC_SETCUR, 8'h00, 8'(COLS), 8'h00);
    queue_cmd(FUNC_SETCUR, 8'h00, 8'h00, 8'(LINES));
    queue_cmd(FUNC_READ, 8'h00, 8'(COLS - 1), 8'(LINES - 2));
    queue_cmd(FUNC_READ, 8'h00, 8'hFF, 8'hFF);
    queue_cmd(FUNC_PUT, CH_CR, 8'h00, 8'h00);

    // random part: text-like traffic in phases, each with a new attribute
    phase = 0;
    next_phase = 0;
    for (k = 0; k < RANDOM_CMDS; k++) begin
      calm_mode = (phase % 4 == 3) || (k >= CALM_FROM);
      if (k == next_phase) begin
        case (phase % 6)
          0:       queue_attr(8'h00);
          1:       queue_attr(8'hFF);
          2:       queue_attr(ATTR_RESET);
          default: queue_attr(8'($urandom_range(0, 255)));
        endcase
        next_phase += $urandom_range(40, 120);
        phase++;
      end
      roll = $urandom_range(0, 99);
      a = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
      c = 8'($urandom_range(0, 255));
      if (roll < 58) begin
        queue_cmd(FUNC_PUT, 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)), b, c);
      end else if (roll < 64) begin
        queue_cmd(FUNC_PUT, roll[0] ? CH_LF : CH_CR, b, c);
      end else if (roll < 68) begin
        queue_cmd(FUNC_PUT, CH_TAB, b, c);
      end else if (roll < 73) begin
        queue_cmd(FUNC_PUT, CH_BACKSPACE, b, c);
      end else if (roll < 77) begin
        // any byte at all, control and high codes included
        queue_cmd(FUNC_PUT, a, b, c);
      end else if (roll < 85) begin
        if ($urandom_range(0, 7) == 0) begin
          queue_cmd(FUNC_SETCUR, a, b, c);
        end else begin
          // lean toward line ends and the bottom row to reach wraps and scrolls
          b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(COLS - 10, COLS - 1))
                                          : 8'($urandom_range(0, COLS - 1));
          c = ($urandom_range(0, 3) == 0) ? 8'(LINES - 1)
                                          : 8'($urandom_range(0, LINES - 1));
          queue_cmd(FUNC_SETCUR, a, b, c);
        end
      end else if (roll < 98) begin
        if ($urandom_range(0, 5) == 0) begin
          queue_cmd(FUNC_READ, a, b, c);
        end else begin
          queue_cmd(FUNC_READ, a, 8'($urandom_range(0, COLS - 1)),
                    8'($urandom_range(0, LINES - 1)));
        end
      end else if (roll == 98) begin
        queue_cmd(FUNC_CLEAR, a, b, c);
      end else begin
        queue_cmd(func_t'($urandom_range(0, 3)), a, b, c);
      end
    end

    // reset, released away from the sampling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain: everything sent, everything returned, then a short quiet spell
    @(posedge clk);
    while (pending.size() != 0 || in_valid || results_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    $display("run covered %0d commands: %0d reads, %0d clears, %0d scrolls",
             n_cmds, n_reads, n_clears, n_scrolls);
    $display("attribute register written %0d times, %0d field mismatches",
             n_attr, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
